// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the column timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rlct_pkg.sv =====
// ----------------------------------------------------------------------------
// rlct_pkg
// Shared types and constants of the rotating LED column timer.
// ----------------------------------------------------------------------------
package rlct_pkg;

	// Register map (index = byte address / 8)
	localparam int          ADDR_W          = 5;
	localparam int          DATA_W          = 64;
	localparam logic [1:0]  REG_DRAW_CENTER = 2'd0;
	localparam logic [1:0]  REG_PIXEL_SPAN  = 2'd1;
	localparam logic [1:0]  REG_GLYPH       = 2'd2;

	// Field widths
	localparam int CENTER_W = 12;
	localparam int SPAN_W   = 9;
	localparam int TIME_W   = 32;
	localparam int IDX_W    = 3;
	localparam int LED_W    = 8;

	// Register reset values
	localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd1800;
	localparam logic [SPAN_W-1:0]   SPAN_RESET   = 9'd50;
	localparam logic [DATA_W-1:0]   GLYPH_RESET  = 64'h0000_C366_3C66_C300;

	// Angle arithmetic
	localparam logic [TIME_W-1:0]   TENTHS_PER_REV = 32'd3600;
	localparam int                  POS_W          = 15;
	localparam logic [POS_W-1:0]    POS_MAX        = 15'd3599;

	// Divider: two quotient bits per step
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = 4;

	// Parameter defaults
	localparam int COLUMNS_DEF = 8;
	localparam int LEDS_DEF    = 8;

	// Controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_FIN   = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture item, start first division
		logic step;      // advance divider by one step
		logic set_tpt;   // store quotient as time per tenth
		logic load_mod;  // start reduction of quotient modulo 3600
		logic check;     // compare angle with column positions
		logic emit;      // load output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tpt_zero;
		logic div_last;
		logic is_edge;
		logic hit;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/rotating_led_column_timer_top.sv =====
// ----------------------------------------------------------------------------
// rotating_led_column_timer_top
// Column timer for a rotating LED bar: period measurement, angle estimate
// and glyph column selection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, timestamp): kind 1 is the
//   once-per-revolution sensor edge, kind 0 a position poll. Output channel
//   (out_valid/out_ready, led_column, column_index) carries the glyph byte of
//   a column the bar has just crossed; a poll gives zero or one transfer.
//   The configuration port writes draw center, pixel span and glyph at byte
//   addresses 0, 8 and 16; the user is to write it only while the block is
//   idle, which the block itself does not enforce. Timing: one item at a time
//   through a shared 2-bit-per-cycle divider. An edge runs capture, 16 divider
//   steps and commit. A poll runs 16 steps for elapsed/time-per-tenth,
//   16 steps for the modulo 3600 reduction, then compare and output load.
//   A poll before the period is known is taken and dropped.
//   Reset clears the edge time, the period and the previous angle; registers
//   return to their defaults. A stalled receiver holds the result in the
//   output register; the block keeps taking items and waits only when a new
//   result is ready while the previous one is still untaken.
// ----------------------------------------------------------------------------
module rotating_led_column_timer_top #(
	parameter int COLUMNS = rlct_pkg::COLUMNS_DEF,
	parameter int LEDS    = rlct_pkg::LEDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rlct_pkg::ADDR_W-1:0]  paddr,
	input  logic [rlct_pkg::DATA_W-1:0]  pwdata,
	output logic [rlct_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [rlct_pkg::TIME_W-1:0]  timestamp,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rlct_pkg::LED_W-1:0]   led_column,
	output logic [rlct_pkg::IDX_W-1:0]   column_index
);

	logic [rlct_pkg::CENTER_W-1:0] draw_center;
	logic [rlct_pkg::SPAN_W-1:0]   pixel_span;
	logic [rlct_pkg::DATA_W-1:0]   glyph_columns;
	rlct_pkg::cmd_t                cmd;
	rlct_pkg::status_t             status;

	rlct_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.draw_center   (draw_center),
		.pixel_span    (pixel_span),
		.glyph_columns (glyph_columns)
	);

	rlct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	rlct_dp #(
		.COLUMNS (COLUMNS),
		.LEDS    (LEDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.timestamp     (timestamp),
		.draw_center   (draw_center),
		.pixel_span    (pixel_span),
		.glyph_columns (glyph_columns),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.led_column    (led_column),
		.column_index  (column_index)
	);

endmodule

// ===== rtl/rlct_regs.sv =====
// ----------------------------------------------------------------------------
// rlct_regs
// APB-style configuration registers: draw center, pixel span, glyph.
// ----------------------------------------------------------------------------
module rlct_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rlct_pkg::ADDR_W-1:0]   paddr,
	input  logic [rlct_pkg::DATA_W-1:0]   pwdata,
	output logic [rlct_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [rlct_pkg::CENTER_W-1:0] draw_center,
	output logic [rlct_pkg::SPAN_W-1:0]   pixel_span,
	output logic [rlct_pkg::DATA_W-1:0]   glyph_columns
);

	logic [rlct_pkg::CENTER_W-1:0] draw_center_q;
	logic [rlct_pkg::SPAN_W-1:0]   pixel_span_q;
	logic [rlct_pkg::DATA_W-1:0]   glyph_q;
	logic                          wr_en;
	logic [1:0]                    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:3];

	// Write on the access cycle; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_center_q <= rlct_pkg::CENTER_RESET;
			pixel_span_q  <= rlct_pkg::SPAN_RESET;
			glyph_q       <= rlct_pkg::GLYPH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				rlct_pkg::REG_DRAW_CENTER: draw_center_q <= pwdata[rlct_pkg::CENTER_W-1:0];
				rlct_pkg::REG_PIXEL_SPAN:  pixel_span_q  <= pwdata[rlct_pkg::SPAN_W-1:0];
				rlct_pkg::REG_GLYPH:       glyph_q       <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			rlct_pkg::REG_DRAW_CENTER: prdata = {52'd0, draw_center_q};
			rlct_pkg::REG_PIXEL_SPAN:  prdata = {55'd0, pixel_span_q};
			rlct_pkg::REG_GLYPH:       prdata = glyph_q;
			default:                   prdata = '0;
		endcase
	end

	assign draw_center   = draw_center_q;
	assign pixel_span    = pixel_span_q;
	assign glyph_columns = glyph_q;

endmodule

// ===== rtl/rlct_dp.sv =====
// ----------------------------------------------------------------------------
// rlct_dp
// Datapath: revolution state, shared radix-4 divider, column compare and
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlct_dp #(
	parameter int COLUMNS = rlct_pkg::COLUMNS_DEF,
	parameter int LEDS    = rlct_pkg::LEDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlct_pkg::cmd_t                cmd,
	output rlct_pkg::status_t             status,
	input  logic                          kind,
	input  logic [rlct_pkg::TIME_W-1:0]   timestamp,
	input  logic [rlct_pkg::CENTER_W-1:0] draw_center,
	input  logic [rlct_pkg::SPAN_W-1:0]   pixel_span,
	input  logic [rlct_pkg::DATA_W-1:0]   glyph_columns,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rlct_pkg::LED_W-1:0]    led_column,
	output logic [rlct_pkg::IDX_W-1:0]    column_index
);

	localparam int                       HALF_COLS = (COLUMNS - 1) / 2;
	localparam logic [rlct_pkg::LED_W-1:0] LED_MASK = 8'((1 << LEDS) - 1);
	localparam int                       TW = rlct_pkg::TIME_W;
	localparam int                       PW = rlct_pkg::POS_W;

	// Revolution state
	logic [TW-1:0]                     last_edge_q;
	logic [TW-1:0]                     tpt_q;
	logic [rlct_pkg::CENTER_W-1:0]     prev_angle_q;
	logic                              is_edge_q;

	// Divider
	logic [TW:0]                       rem_q;
	logic [TW-1:0]                     quo_q;
	logic [TW-1:0]                     dvs_q;
	logic [rlct_pkg::CNT_W-1:0]        cnt_q;
	logic [2*TW:0]                     step_res;
	logic [TW-1:0]                     delta;

	// Column compare
	logic [PW-1:0]                     base;
	logic [PW-1:0]                     span_x;
	logic [PW-1:0]                     pos;
	logic [PW-1:0]                     angle_x;
	logic [PW-1:0]                     prev_x;
	logic                              found;
	logic [rlct_pkg::IDX_W-1:0]        found_idx;
	logic                              hit_q;
	logic [rlct_pkg::IDX_W-1:0]        idx_q;

	// Output register
	logic                              out_valid_q;
	logic [rlct_pkg::LED_W-1:0]        led_q;
	logic [rlct_pkg::IDX_W-1:0]        col_q;

	// Two restoring division steps; remainder always stays below divisor
	function automatic logic [2*TW:0] div_step(
		input logic [TW:0]   rem,
		input logic [TW-1:0] quo,
		input logic [TW-1:0] dvs
	);
		logic [TW:0]   r;
		logic [TW-1:0] q;
		r = rem;
		q = quo;
		for (int k = 0; k < 2; k++) begin
			r = {r[TW-1:0], q[TW-1]};
			q = {q[TW-2:0], 1'b0};
			if (r >= {1'b0, dvs}) begin
				r = r - {1'b0, dvs};
				q[0] = 1'b1;
			end
		end
		return {r, q};
	endfunction

	assign delta    = timestamp - last_edge_q;
	assign step_res = div_step(rem_q, quo_q, dvs_q);

	// Divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= delta;
			dvs_q <= kind ? rlct_pkg::TENTHS_PER_REV : tpt_q;
		end else if (cmd.load_mod) begin
			rem_q <= '0;
			dvs_q <= rlct_pkg::TENTHS_PER_REV;
		end else if (cmd.step) begin
			rem_q <= step_res[2*TW:TW];
			quo_q <= step_res[TW-1:0];
		end
	end

	// Step counter and item kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			is_edge_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				is_edge_q <= kind;
			end
			if (cmd.load || cmd.load_mod) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Revolution state: edge time, time per tenth, previous angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q  <= '0;
			tpt_q        <= '0;
			prev_angle_q <= '0;
		end else begin
			if (cmd.load && kind) begin
				last_edge_q <= timestamp;
			end
			if (cmd.set_tpt) begin
				tpt_q <= quo_q;
			end
			if (cmd.check) begin
				prev_angle_q <= rem_q[rlct_pkg::CENTER_W-1:0];
			end
		end
	end

	// Column positions around the draw center; lowest crossed column wins
	assign span_x  = PW'(pixel_span);
	assign base    = PW'(draw_center) - PW'(pixel_span[rlct_pkg::SPAN_W-1:1])
		- PW'(HALF_COLS) * span_x;
	assign angle_x = PW'(rem_q[rlct_pkg::CENTER_W-1:0]);
	assign prev_x  = PW'(prev_angle_q);

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		pos       = '0;
		for (int i = COLUMNS - 1; i >= 0; i--) begin
			pos = base + PW'(i) * span_x;
			if (!pos[PW-1] && pos <= rlct_pkg::POS_MAX
					&& prev_x < pos && angle_x > pos) begin
				found     = 1'b1;
				found_idx = rlct_pkg::IDX_W'(i);
			end
		end
	end

	// Hold compare result until the output slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.check) begin
			hit_q <= found;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			idx_q <= found_idx;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			led_q <= glyph_columns[idx_q*rlct_pkg::LED_W +: rlct_pkg::LED_W] & LED_MASK;
			col_q <= idx_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign led_column   = led_q;
	assign column_index = col_q;

	assign status.tpt_zero = (tpt_q == '0);
	assign status.div_last = (cnt_q == rlct_pkg::CNT_W'(rlct_pkg::DIV_STEPS - 1));
	assign status.is_edge  = is_edge_q;
	assign status.hit      = hit_q;
	assign status.out_free = !out_valid_q || out_ready;

	`ASSERT_SAME(a_dvs_nonzero, clk, arst_n, cmd.step, dvs_q != '0,
		"divider runs with zero divisor")
	`ASSERT_SAME(a_rem_below, clk, arst_n, cmd.step, rem_q < (TW + 1)'(dvs_q),
		"divider remainder not below divisor")
	`ASSERT_SAME(a_emit_hit, clk, arst_n, cmd.emit, hit_q && status.out_free,
		"emit without a crossed column or free slot")

endmodule

// ===== rtl/rlct_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlct_ctrl
// Controller: sequences capture, period/angle division, modulo reduction,
// column compare and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                kind,
	output logic                in_ready,
	output rlct_pkg::cmd_t      cmd,
	input  rlct_pkg::status_t   status
);

	rlct_pkg::state_t state_q;
	rlct_pkg::state_t state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rlct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// drop polls before the period is known
				if (in_valid && (kind || !status.tpt_zero)) begin
					cmd.load = 1'b1;
					state_d  = rlct_pkg::ST_DIV;
				end
			end
			rlct_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = rlct_pkg::ST_FIN;
				end
			end
			rlct_pkg::ST_FIN: begin
				if (status.is_edge) begin
					cmd.set_tpt = 1'b1;
					state_d     = rlct_pkg::ST_IDLE;
				end else begin
					cmd.load_mod = 1'b1;
					state_d      = rlct_pkg::ST_MOD;
				end
			end
			rlct_pkg::ST_MOD: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = rlct_pkg::ST_CHECK;
				end
			end
			rlct_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = rlct_pkg::ST_EMIT;
			end
			rlct_pkg::ST_EMIT: begin
				if (!status.hit) begin
					state_d = rlct_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = rlct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlct_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_div_to_fin, clk, arst_n,
		state_q == rlct_pkg::ST_DIV && status.div_last, state_q == rlct_pkg::ST_FIN,
		"division did not finish after last step")

endmodule
